// ===== hw/rtl/hfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfcc_pkg
// Shared types and constants of the HSV frame colour classifier.
// ----------------------------------------------------------------------------
package hfcc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_RED_LOW_HUE_MAX  = 3'd0;
  localparam logic [2:0] REG_RED_HIGH_HUE_MIN = 3'd1;
  localparam logic [2:0] REG_RED_SAT_MIN      = 3'd2;
  localparam logic [2:0] REG_RED_VAL_MIN      = 3'd3;
  localparam logic [2:0] REG_GREEN_HUE_MIN    = 3'd4;
  localparam logic [2:0] REG_GREEN_HUE_MAX    = 3'd5;

  // frame class codes
  localparam logic [1:0] CLASS_RED   = 2'd0;
  localparam logic [1:0] CLASS_GREEN = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  // reciprocal divider geometry: numerators 2*K*4096 + x, denominators 2*x
  localparam int DIV_NUM_W = 21;
  localparam int DIV_DEN_W = 9;
  localparam logic [20:0] SAT_NUM_BASE = 21'd2088960;  // 2*255*4096
  localparam logic [20:0] HUE_NUM_BASE = 21'd245760;   // 2*30*4096

  // hue wrap and upper hue limit
  localparam logic signed [17:0] HUE_WRAP = 18'sd180;

  typedef struct packed {
    logic [7:0] red_low_hue_max;
    logic [7:0] red_high_hue_min;
    logic [7:0] red_sat_min;
    logic [7:0] red_val_min;
    logic [7:0] green_hue_min;
    logic [7:0] green_hue_max;
  } cfg_t;

  // pre-division pixel terms handed from front to back
  typedef struct packed {
    logic [7:0]  v;      // max channel
    logic [7:0]  d;      // max minus min
    logic [11:0] h6;     // signed sextant hue term
    logic        last;   // frame end mark
  } entry_t;

endpackage

// ===== hw/rtl/hsv_frame_color_classifier_top.sv =====
// ----------------------------------------------------------------------------
// hsv_frame_color_classifier_top
// Converts BGR pixels to HSV and classifies each frame as red, green or other.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// pixel    in         in_valid / in_ready    blue_level, green_level,
//                                            red_level, frame_end
// result   out        out_valid / out_ready  color_class
// config   in         cfg_we                 cfg_index, cfg_data
//
// each pixel holds the back end from issue in IDLE through DIV, while the two
// restoring reciprocal dividers run side by side, to multiply and class states;
// the front stage and a QUEUE_DEPTH queue keep taking pixels while back works
// reset is synchronous and active high; thresholds return to their defaults
// a pending result holds only a later frame end, not the pixels before it
// ----------------------------------------------------------------------------
module hsv_frame_color_classifier_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] blue_level,
  input  logic [7:0] green_level,
  input  logic [7:0] red_level,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] color_class,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  hfcc_pkg::cfg_t   cfg;
  hfcc_pkg::entry_t f_entry;
  hfcc_pkg::entry_t b_entry;
  logic             f_valid;
  logic             f_ready;
  logic             b_valid;
  logic             b_ready;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_low_hue_max  <= 8'd10;
      cfg.red_high_hue_min <= 8'd170;
      cfg.red_sat_min      <= 8'd120;
      cfg.red_val_min      <= 8'd70;
      cfg.green_hue_min    <= 8'd36;
      cfg.green_hue_max    <= 8'd86;
    end else if (cfg_we) begin
      case (cfg_index)
        hfcc_pkg::REG_RED_LOW_HUE_MAX:  cfg.red_low_hue_max  <= cfg_data;
        hfcc_pkg::REG_RED_HIGH_HUE_MIN: cfg.red_high_hue_min <= cfg_data;
        hfcc_pkg::REG_RED_SAT_MIN:      cfg.red_sat_min      <= cfg_data;
        hfcc_pkg::REG_RED_VAL_MIN:      cfg.red_val_min      <= cfg_data;
        hfcc_pkg::REG_GREEN_HUE_MIN:    cfg.green_hue_min    <= cfg_data;
        hfcc_pkg::REG_GREEN_HUE_MAX:    cfg.green_hue_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel intake
  hfcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .blue_level  (blue_level),
    .green_level (green_level),
    .red_level   (red_level),
    .frame_end   (frame_end),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_entry     (f_entry)
  );

  // decoupling queue
  hfcc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_entry (f_entry),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_entry (b_entry)
  );

  // conversion and frame classification
  hfcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .q_entry     (b_entry),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color_class (color_class)
  );

endmodule

// ===== hw/rtl/hfcc_front.sv =====
// ----------------------------------------------------------------------------
// hfcc_front
// Pixel intake: max, min, chroma and sextant hue term, one register stage.
// ----------------------------------------------------------------------------
module hfcc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      blue_level,
  input  logic [7:0]      green_level,
  input  logic [7:0]      red_level,
  input  logic            frame_end,
  output logic            q_valid,
  input  logic            q_ready,
  output hfcc_pkg::entry_t q_entry
);

  logic [7:0]        vmax;
  logic [7:0]        vmin;
  logic [7:0]        chroma;
  logic signed [11:0] sb;
  logic signed [11:0] sg;
  logic signed [11:0] sr;
  logic signed [11:0] h6;
  logic              full;
  hfcc_pkg::entry_t  ent;

  // max and min of the three channels
  always_comb begin
    vmax = blue_level;
    if (green_level > vmax) vmax = green_level;
    if (red_level > vmax) vmax = red_level;
    vmin = blue_level;
    if (green_level < vmin) vmin = green_level;
    if (red_level < vmin) vmin = red_level;
  end

  assign chroma = vmax - vmin;
  assign sb = $signed({4'b0, blue_level});
  assign sg = $signed({4'b0, green_level});
  assign sr = $signed({4'b0, red_level});

  // sextant term, red first, then green
  always_comb begin
    if (vmax == red_level) begin
      h6 = sg - sb;
    end else if (vmax == green_level) begin
      h6 = sb - sr + $signed({3'b0, chroma, 1'b0});
    end else begin
      h6 = sr - sg + $signed({2'b0, chroma, 2'b0});
    end
  end

  assign in_ready = !full || q_ready;

  // output stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (q_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent.v    <= vmax;
      ent.d    <= chroma;
      ent.h6   <= h6;
      ent.last <= frame_end;
    end
  end

  assign q_valid = full;
  assign q_entry = ent;

endmodule

// ===== hw/rtl/hfcc_fifo.sv =====
// ----------------------------------------------------------------------------
// hfcc_fifo
// Small queue of pixel terms between front and back.
// ----------------------------------------------------------------------------
module hfcc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  hfcc_pkg::entry_t wr_entry,
  output logic             rd_valid,
  input  logic             rd_ready,
  output hfcc_pkg::entry_t rd_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hfcc_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_entry = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue fill count beyond depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue fill count missed a write");
`endif

endmodule

// ===== hw/rtl/hfcc_div.sv =====
// ----------------------------------------------------------------------------
// hfcc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hfcc_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int KW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [KW-1:0]    steps;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one trial subtraction
  assign rem_sh = {rem, num_sh[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= KW'(NUM_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
    end else if (steps != '0) begin
      num_sh <= {num_sh[NUM_W-2:0], fits};
      rem    <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy = (steps != '0);
  assign quot = num_sh;

endmodule

// ===== hw/rtl/hfcc_back.sv =====
// ----------------------------------------------------------------------------
// hfcc_back
// Per-pixel saturation and hue, band tests, sticky frame flags and result.
// ----------------------------------------------------------------------------
module hfcc_back (
  input  logic             clk,
  input  logic             rst,
  input  hfcc_pkg::cfg_t   cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  hfcc_pkg::entry_t q_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       color_class
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_CLASS = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  hfcc_pkg::entry_t ent;
  logic                          div_start;
  logic                          s_busy;
  logic                          h_busy;
  logic [hfcc_pkg::DIV_NUM_W-1:0] s_quot;
  logic [hfcc_pkg::DIV_NUM_W-1:0] h_quot;
  logic [19:0]                   sdiv;
  logic [16:0]                   hdiv;
  logic [27:0]                   s_prod;
  logic signed [29:0]            h_prod;
  logic [27:0]                   s_sum;
  logic [15:0]                   sat;
  logic signed [29:0]            h_sum;
  logic signed [17:0]            h_raw;
  logic signed [17:0]            hue;
  logic                          sv_ok;
  logic                          is_red;
  logic                          is_green;
  logic                          commit;
  logic                          all_red;
  logic                          all_green;

  assign q_ready   = (state == ST_IDLE);
  assign div_start = (state == ST_IDLE) && q_valid;

  // saturation reciprocal: round(255*4096 / v)
  hfcc_div #(
    .NUM_W (hfcc_pkg::DIV_NUM_W),
    .DEN_W (hfcc_pkg::DIV_DEN_W)
  ) u_sat_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (hfcc_pkg::SAT_NUM_BASE + {13'b0, q_entry.v}),
    .den   ({q_entry.v, 1'b0}),
    .busy  (s_busy),
    .quot  (s_quot)
  );

  // hue reciprocal: round(30*4096 / d)
  hfcc_div #(
    .NUM_W (hfcc_pkg::DIV_NUM_W),
    .DEN_W (hfcc_pkg::DIV_DEN_W)
  ) u_hue_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (hfcc_pkg::HUE_NUM_BASE + {13'b0, q_entry.d}),
    .den   ({q_entry.d, 1'b0}),
    .busy  (h_busy),
    .quot  (h_quot)
  );

  // zero max or zero chroma gives a zero reciprocal
  assign sdiv = (ent.v == 8'd0) ? 20'd0 : s_quot[19:0];
  assign hdiv = (ent.d == 8'd0) ? 17'd0 : h_quot[16:0];

  // rounding and hue wrap
  assign s_sum = s_prod + 28'd2048;
  assign sat   = s_sum[27:12];
  assign h_sum = h_prod + 30'sd2048;
  assign h_raw = h_sum[29:12];
  assign hue   = (h_raw < 0) ? h_raw + hfcc_pkg::HUE_WRAP : h_raw;

  // band tests
  assign sv_ok = (sat >= {8'b0, cfg.red_sat_min}) && (ent.v >= cfg.red_val_min);
  assign is_red = sv_ok &&
                  ((hue <= $signed({10'b0, cfg.red_low_hue_max})) ||
                   ((hue >= $signed({10'b0, cfg.red_high_hue_min})) &&
                    (hue <= hfcc_pkg::HUE_WRAP)));
  assign is_green = (hue >= $signed({10'b0, cfg.green_hue_min})) &&
                    (hue <= $signed({10'b0, cfg.green_hue_max}));

  // a frame end waits for a free result register
  assign commit = (state == ST_CLASS) && (!ent.last || !out_valid || out_ready);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_valid) state_next = ST_DIV;
      ST_DIV:   if (!s_busy && !h_busy) state_next = ST_MUL;
      ST_MUL:   state_next = ST_CLASS;
      ST_CLASS: if (commit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel terms and products
  always_ff @(posedge clk) begin
    if (div_start) ent <= q_entry;
    if (state == ST_MUL) begin
      s_prod <= 28'(ent.d) * 28'(sdiv);
      h_prod <= $signed({{18{ent.h6[11]}}, ent.h6}) * $signed({13'b0, hdiv});
    end
  end

  // sticky flags and result register; a new frame end refills it as the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      all_red   <= 1'b1;
      all_green <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (commit && ent.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        if (ent.last) begin
          all_red   <= 1'b1;
          all_green <= 1'b1;
        end else begin
          all_red   <= all_red && is_red;
          all_green <= all_green && is_green;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && ent.last) begin
      if (all_red && is_red) begin
        color_class <= hfcc_pkg::CLASS_RED;
      end else if (all_green && is_green) begin
        color_class <= hfcc_pkg::CLASS_GREEN;
      end else begin
        color_class <= hfcc_pkg::CLASS_OTHER;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (!s_busy && !h_busy))
    else $error("products taken before the dividers finished");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(commit && ent.last))
    else $error("result raised without a frame end");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (commit && ent.last) |=> (all_red && all_green))
    else $error("frame flags not rearmed after frame end");
`endif

endmodule
